// ===== hw/rtl/pfht_pkg.sv =====
package pfht_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam int SUM_W = 33;

	// Request as it leaves the front part: the key sum is already formed.
	typedef struct packed {
		op_t         op;
		logic [31:0] file_id;
		logic [31:0] page_no;
		logic [15:0] frame_in;
		logic [32:0] key_sum;
	} req_t;

endpackage

// ===== hw/rtl/pfht_ram.sv =====
module pfht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/pfht_front.sv =====
module pfht_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [31:0]       file_id,
	input  logic [31:0]       page_no,
	input  logic [15:0]       frame_in,
	output logic              q_valid,
	input  logic              q_pop,
	output pfht_pkg::req_t    q_head
);

	// Two-entry queue toward the back part.
	pfht_pkg::req_t slot_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	logic           push;
	pfht_pkg::req_t req;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = slot_q[rd_q];

	// Classify the transaction and form the 33-bit key sum.
	always_comb begin
		req.op       = pfht_pkg::op_t'(op);
		req.file_id  = file_id;
		req.page_no  = page_no;
		req.frame_in = frame_in;
		req.key_sum  = {1'b0, file_id} + {1'b0, page_no};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== hw/rtl/pfht_back.sv =====
module pfht_back #(
	parameter int MAX_BUCKETS = 128,
	parameter int ENTRIES     = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        bucket_count,
	input  logic              q_valid,
	output logic              q_pop,
	input  pfht_pkg::req_t    q_head,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [15:0]       frame_found
);

	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int EW = $clog2(ENTRIES);
	localparam int LW = EW + 1;
	localparam int CW = EW + 1;
	localparam int DW = BW + 1;
	localparam int RW = 34;
	localparam int KEY_W = 64 + 16;
	localparam int ROW_W = KEY_W + LW;
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MOD   = 9'b000000010,
		S_HEAD  = 9'b000000100,
		S_HWAIT = 9'b000001000,
		S_RD    = 9'b000010000,
		S_CMP   = 9'b000100000,
		S_FREE  = 9'b001000000,
		S_FWAIT = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t          state_q;
	pfht_pkg::req_t  req_q;
	logic [RW-1:0]   rem_q;
	logic [5:0]      bit_q;
	logic [DW-1:0]   div_q;
	logic [BW-1:0]   bkt_q;
	logic [LW-1:0]   cur_q, prev_q;
	logic [CW-1:0]   steps_q;
	logic [CW-1:0]   free_cnt_q;
	logic [MAX_BUCKETS-1:0] head_ok_q;
	logic [1:0]      st_q;
	logic [15:0]     fr_q;
	logic            ov_q;
	logic [EW-1:0]   fslot_q;
	logic [ENTRIES-1:0] fvalid_q;
	logic [KEY_W-1:0] prow_q;
	logic            pfix_q;

	// Head table, entry rows and free stack.
	logic            h_we;
	logic [BW-1:0]   h_wa, h_ra;
	logic [LW-1:0]   h_wd, h_rd;
	logic            e_we;
	logic [EW-1:0]   e_wa, e_ra;
	logic [ROW_W-1:0] e_wd, e_rd;
	logic            f_we;
	logic [EW-1:0]   f_wa, f_ra;
	logic [EW-1:0]   f_wd, f_rd;
	logic            f_ok_q;

	pfht_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	pfht_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_rows (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
	pfht_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

	logic [31:0]   row_file, row_page;
	logic [15:0]   row_frame;
	logic [LW-1:0] row_link;
	assign {row_file, row_page, row_frame, row_link} = e_rd;

	logic          hit;
	logic          chain_end;
	logic [LW-1:0] head_val;
	logic [RW-1:0] trial;
	logic [DW-1:0] div_eff;
	logic [EW-1:0] new_e;
	logic [EW-1:0] f_raw;

	assign head_val  = head_ok_q[bkt_q] ? h_rd : NIL;
	assign hit       = (row_file == req_q.file_id) && (row_page == req_q.page_no);
	assign chain_end = (cur_q >= NIL) || (steps_q >= CW'(ENTRIES));
	assign trial     = {rem_q[RW-2:0], req_q.key_sum[bit_q]} - RW'(div_q);
	// Slots never pushed hold their own index.
	assign f_raw     = f_ok_q ? f_rd : fslot_q;
	assign new_e     = f_raw;

	// Clamp the divisor into its legal range.
	always_comb begin
		if (bucket_count == 8'd0) begin
			div_eff = DW'(1);
		end else if ({24'd0, bucket_count} > 32'(MAX_BUCKETS)) begin
			div_eff = DW'(MAX_BUCKETS);
		end else begin
			div_eff = DW'(bucket_count);
		end
	end

	assign q_pop       = (state_q == S_IDLE) && q_valid && !ov_q;
	assign out_valid   = ov_q;
	assign status      = st_q;
	assign frame_found = fr_q;

	// Memory port control.
	always_comb begin
		h_we = 1'b0; h_wa = bkt_q; h_wd = NIL; h_ra = bkt_q;
		e_we = 1'b0; e_wa = new_e; e_ra = cur_q[EW-1:0];
		e_wd = {req_q.file_id, req_q.page_no, req_q.frame_in, head_val};
		f_we = 1'b0; f_wa = free_cnt_q[EW-1:0]; f_wd = cur_q[EW-1:0];
		f_ra = free_cnt_q[EW-1:0];
		case (state_q)
			S_CMP: begin
				if (pfix_q && !chain_end && hit && req_q.op == pfht_pkg::OP_REMOVE) begin
					if (prev_q == NIL) begin
						h_we = 1'b1;
						h_wd = row_link;
					end else begin
						// The previous entry keeps its key and takes over the link.
						e_we = 1'b1;
						e_wa = prev_q[EW-1:0];
						e_wd = {prow_q, row_link};
						e_ra = prev_q[EW-1:0];
					end
					if (free_cnt_q < CW'(ENTRIES)) f_we = 1'b1;
				end
			end
			S_FWAIT: begin
				e_we = 1'b1;
				h_we = 1'b1;
				h_wd = {1'b0, new_e};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ov_q       <= 1'b0;
			free_cnt_q <= CW'(ENTRIES);
			head_ok_q  <= '0;
			fvalid_q   <= '0;
			f_ok_q     <= 1'b0;
			pfix_q     <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			f_ok_q <= fvalid_q[f_ra];
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_MOD;
						req_q   <= q_head;
						rem_q   <= '0;
						bit_q   <= 6'd32;
						div_q   <= div_eff;
					end
				end
				// Restoring remainder, one bit a cycle.
				S_MOD: begin
					if (!trial[RW-1]) rem_q <= trial;
					else rem_q <= {rem_q[RW-2:0], req_q.key_sum[bit_q]};
					if (bit_q == 6'd0) state_q <= S_HEAD;
					else bit_q <= bit_q - 6'd1;
				end
				S_HEAD: begin
					bkt_q   <= rem_q[BW-1:0];
					state_q <= S_HWAIT;
				end
				S_HWAIT: state_q <= S_RD;
				S_RD: begin
					cur_q   <= head_val;
					prev_q  <= NIL;
					steps_q <= '0;
					if (req_q.op == pfht_pkg::OP_NONE) begin
						st_q <= pfht_pkg::ST_NOT_FOUND; fr_q <= '0; state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					// Row data for cur_q arrives in the cycle after its address.
					if (!pfix_q) begin
						pfix_q <= 1'b1;
					end else begin
						pfix_q <= 1'b0;
						if (chain_end) begin
							fr_q <= '0;
							if (req_q.op == pfht_pkg::OP_INSERT) begin
								if (free_cnt_q == '0 || free_cnt_q > CW'(ENTRIES)) begin
									st_q <= pfht_pkg::ST_FULL; state_q <= S_DONE;
								end else begin
									free_cnt_q <= free_cnt_q - CW'(1);
									state_q <= S_FREE;
								end
							end else begin
								st_q <= pfht_pkg::ST_NOT_FOUND; state_q <= S_DONE;
							end
						end else if (hit) begin
							state_q <= S_DONE;
							case (req_q.op)
								pfht_pkg::OP_LOOKUP: begin
									st_q <= pfht_pkg::ST_OK; fr_q <= row_frame;
								end
								pfht_pkg::OP_INSERT: begin
									st_q <= pfht_pkg::ST_PRESENT; fr_q <= '0;
								end
								default: begin
									st_q <= pfht_pkg::ST_OK;
									fr_q <= '0;
									if (free_cnt_q < CW'(ENTRIES)) begin
										free_cnt_q <= free_cnt_q + CW'(1);
										fvalid_q[free_cnt_q[EW-1:0]] <= 1'b1;
									end
								end
							endcase
						end else begin
							prev_q  <= cur_q;
							prow_q  <= {row_file, row_page, row_frame};
							cur_q   <= row_link;
							steps_q <= steps_q + CW'(1);
						end
					end
				end
				S_FREE: state_q <= S_FWAIT;
				S_FWAIT: begin
					st_q <= pfht_pkg::ST_OK; state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q) begin
						ov_q <= 1'b1; state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_FWAIT) head_ok_q[bkt_q] <= 1'b1;
			if (state_q == S_CMP && pfix_q && !chain_end && hit
			    && req_q.op == pfht_pkg::OP_REMOVE && prev_q == NIL) begin
				head_ok_q[bkt_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fslot_q <= '0;
		else fslot_q <= f_ra;
	end

endmodule

// ===== hw/rtl/page_frame_hash_table.sv =====
// page_frame_hash_table: maps (file_id, page_no) to a buffer frame number.
// Input channel: in_valid/in_stall with op, file_id, page_no, frame_in.
// op 0 looks a key up, 1 inserts it with frame_in, 2 removes it.
// Output channel: out_valid/out_stall with status and frame_found, one
// result transaction per request, in request order.
// bucket_count is written through cfg_we/cfg_wdata; the user is to write it
// only while the block is idle, and the block itself does not enforce this.
// A front stage forms the key sum and queues up to two requests; the back
// part computes the bucket with a bit-serial remainder, reads the chain
// head in states S_HEAD, S_HWAIT and S_RD, then walks the chain entry by
// entry. The back part takes a new request only after the result of the
// last one has been taken by the receiver.
// Reset empties all chains and makes all entries free at once; no clearing
// pass is needed. A stalled result holds; the queue keeps accepting
// until full.
module page_frame_hash_table #(
	parameter int MAX_BUCKETS = 128,
	parameter int ENTRIES     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] file_id,
	input  logic [31:0] page_no,
	input  logic [15:0] frame_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] frame_found
);

	logic [7:0]     bc_q;
	logic           q_valid, q_pop;
	pfht_pkg::req_t q_head;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= 8'd128;
		end else if (cfg_we) begin
			bc_q <= cfg_wdata;
		end
	end

	pfht_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .file_id(file_id), .page_no(page_no), .frame_in(frame_in),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	pfht_back #(.MAX_BUCKETS(MAX_BUCKETS), .ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .bucket_count(bc_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .frame_found(frame_found));

`ifndef NO_ASSERTIONS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_found))
		else $error("result changed while stalled");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pfht_pkg::ST_OK |-> frame_found == 16'd0)
		else $error("frame_found nonzero on failure");
`endif

endmodule

// ===== dv/page_frame_hash_table_checker.sv =====
`timescale 1ns / 100ps

module page_frame_hash_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] file_id,
	input  logic [31:0] page_no,
	input  logic [15:0] frame_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [15:0] frame_found,
	output int          fail_count,
	output int          pending
);

	localparam int NBKT = 128;
	localparam int NENT = 64;
	localparam logic [6:0] NIL = 7'd64;

	typedef struct packed {
		pfht_pkg::status_t st;
		logic [15:0]       frame;
	} lookup_result_t;

	// Shadow copy of the table.
	logic [7:0]  divisor;
	logic [6:0]  heads [NBKT];
	logic [31:0] key_file [NENT];
	logic [31:0] key_page [NENT];
	logic [15:0] stored_frame [NENT];
	logic [6:0]  next_link [NENT];
	logic [5:0]  free_slots [NENT];
	int          free_total;
	lookup_result_t awaited [$];

	assign pending = awaited.size();

	// Computes the answer to one request and updates the shadow table.
	function automatic lookup_result_t apply_request(logic [1:0] rop, logic [31:0] f,
			logic [31:0] p, logic [15:0] fr);
		lookup_result_t r;
		logic [32:0] sum;
		int d, b, cur, prev, hit, steps, e;
		r.st = pfht_pkg::ST_NOT_FOUND;
		r.frame = '0;
		d = (divisor == 0) ? 1 : ((divisor > NBKT) ? NBKT : int'(divisor));
		sum = {1'b0, f} + {1'b0, p};
		b = int'(sum % 33'(d));
		cur = int'(heads[b]);
		prev = int'(NIL);
		hit = int'(NIL);
		steps = 0;
		while (steps < NENT && cur < NENT && hit == NIL) begin
			if (key_file[cur] == f && key_page[cur] == p)
				hit = cur;
			else begin
				prev = cur;
				cur = int'(next_link[cur]);
			end
			steps++;
		end
		case (pfht_pkg::op_t'(rop))
			pfht_pkg::OP_LOOKUP: begin
				if (hit != NIL) begin
					r.st = pfht_pkg::ST_OK;
					r.frame = stored_frame[hit];
				end
			end
			pfht_pkg::OP_INSERT: begin
				if (hit != NIL)
					r.st = pfht_pkg::ST_PRESENT;
				else if (free_total == 0)
					r.st = pfht_pkg::ST_FULL;
				else begin
					free_total--;
					e = int'(free_slots[free_total]);
					key_file[e] = f;
					key_page[e] = p;
					stored_frame[e] = fr;
					next_link[e] = heads[b];
					heads[b] = 7'(e);
					r.st = pfht_pkg::ST_OK;
				end
			end
			pfht_pkg::OP_REMOVE: begin
				if (hit != NIL) begin
					if (prev != NIL)
						next_link[prev] = next_link[hit];
					else
						heads[b] = next_link[hit];
					next_link[hit] = NIL;
					free_slots[free_total] = 6'(hit);
					free_total++;
					r.st = pfht_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Track configuration, predict accepted requests, compare results.
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			divisor <= 8'd128;
			for (int i = 0; i < NBKT; i++) heads[i] = NIL;
			for (int i = 0; i < NENT; i++) begin
				next_link[i] = NIL;
				free_slots[i] = 6'(i);
			end
			free_total = NENT;
			awaited.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we)
				divisor <= cfg_wdata;
			if (in_valid && !in_stall)
				awaited.push_back(apply_request(op, file_id, page_no, frame_in));
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$display("%0t: expected no result, got status=%0d frame=%0d", $time,
						status, frame_found);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited.pop_front();
					if (status !== want.st || frame_found !== want.frame) begin
						$display("%0t: expected status=%0d frame=%0d, got status=%0d frame=%0d",
							$time, want.st, want.frame, status, frame_found);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/page_frame_hash_table_test.sv =====
`timescale 1ns / 100ps

module page_frame_hash_table_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = pfht_pkg::OP_LOOKUP;
	logic [31:0] file_id = '0;
	logic [31:0] page_no = '0;
	logic [15:0] frame_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] frame_found;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 23;
	int          recv_idle_pct = 74;
	int          cycles = 0;
	logic [31:0] pool_file [16];
	logic [31:0] pool_page [16];

	always #4 clk = ~clk;

	page_frame_hash_table dut (.*);

	page_frame_hash_table_checker checker_i (.*);

	// Receiver stalls at random.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Sends one request transaction, with random idle cycles ahead of it.
	task automatic send(logic [1:0] o, logic [31:0] f, logic [31:0] p, logic [15:0] fr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		file_id <= f;
		page_no <= p;
		frame_in <= fr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_divisor(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic over a small key pool so that hits, removes and a full pool occur.
	task automatic random_phase(int n);
		int k;
		logic [1:0] o;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(15);
			o = ($urandom_range(99) < 4) ? pfht_pkg::OP_NONE
				: pfht_pkg::op_t'($urandom_range(2));
			if ($urandom_range(9) == 0)
				send(o, $urandom, $urandom, 16'($urandom));
			else
				send(o, pool_file[k], pool_page[k], 16'($urandom));
			if ($urandom_range(199) == 0) begin
				for (int j = 0; j < 70; j++)
					send(pfht_pkg::OP_INSERT, $urandom, $urandom, 16'($urandom));
				for (int j = 0; j < 16; j++)
					send(pfht_pkg::OP_REMOVE, pool_file[j], pool_page[j], '0);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) begin
			pool_file[i] = (i < 4) ? {32{i[0]}} : $urandom;
			pool_page[i] = (i < 4) ? {32{i[1]}} : $urandom;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every operation, duplicate, unused opcode.
		send(pfht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send(pfht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234);
		send(pfht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		send(pfht_pkg::OP_INSERT, 32'h0, 32'h0, 16'h0);
		send(pfht_pkg::OP_INSERT, 32'h80, 32'h0, 16'hAAAA);
		send(pfht_pkg::OP_LOOKUP, 32'h0, 32'h0, '0);
		send(pfht_pkg::OP_LOOKUP, 32'h80, 32'h0, '0);
		send(pfht_pkg::OP_NONE, 32'h0, 32'h0, 16'hFFFF);
		send(pfht_pkg::OP_REMOVE, 32'h0, 32'h0, '0);
		send(pfht_pkg::OP_REMOVE, 32'h0, 32'h0, '0);
		send(pfht_pkg::OP_LOOKUP, 32'h80, 32'h0, '0);
		send(pfht_pkg::OP_LOOKUP, 32'h0, 32'h0, '0);
		drain();

		// Pool exhaustion with a one-bucket table, then a duplicate when full.
		set_divisor(8'd1);
		for (int i = 0; i < 63; i++) send(pfht_pkg::OP_INSERT, 32'(i), 32'h100, 16'(i));
		send(pfht_pkg::OP_INSERT, 32'h5, 32'h100, '0);
		send(pfht_pkg::OP_INSERT, 32'h5555, 32'h5555, '0);
		send(pfht_pkg::OP_LOOKUP, 32'h0, 32'h100, '0);
		for (int i = 0; i < 63; i++) send(pfht_pkg::OP_REMOVE, 32'(i), 32'h100, '0);
		drain();

		// Random phases under each idle pattern and several divisors.
		send_idle_pct = 23;
		recv_idle_pct = 74;
		set_divisor(8'd0);
		random_phase(200);
		drain();
		set_divisor(8'd255);
		random_phase(80);
		drain();
		send_idle_pct = 74;
		recv_idle_pct = 23;
		set_divisor(8'd7);
		random_phase(200);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_divisor(8'd128);
		random_phase(200);
		drain();
		set_divisor(8'd129);
		random_phase(80);
		drain();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
